[rtl/dfwm_pkg.sv]
// ----------------------------------------------------------------------------
// dfwm_pkg
// Shared types and constants of the drive fault window monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package dfwm_pkg;

   // Fixed-point one in Q16.16
   localparam int ONE_Q16 = 65536;

   // Request and response payload widths
   localparam int REQ_DATA_W  = 128;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int COUNT_W     = 8;

   // Queue between classifier and counter stage
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Register reset values
   localparam logic [30:0] MIN_IMP_RESET    = 31'd655360;
   localparam logic [30:0] MAX_IMP_RESET    = 31'd65536000;
   localparam logic [23:0] PHASE_TOL_RESET  = 24'd6554;
   localparam logic [23:0] POWER_TOL_RESET  = 24'd6554;
   localparam logic [30:0] TARGET_PWR_RESET = 31'd6553600;
   localparam logic [7:0]  FAIL_LIMIT_RESET = 8'd10;

   // Register indexes (byte address / 4)
   typedef enum logic [2:0] {
      CSR_MIN_IMP    = 3'd0,
      CSR_MAX_IMP    = 3'd1,
      CSR_PHASE_TOL  = 3'd2,
      CSR_POWER_TOL  = 3'd3,
      CSR_TARGET_PWR = 3'd4,
      CSR_FAIL_LIMIT = 3'd5
   } csr_index_type;

   // Request action
   localparam logic ACTION_SAMPLE  = 1'b0;
   localparam logic ACTION_RESTART = 1'b1;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_IMPEDANCE = 2'd1,
      FAULT_PHASE     = 2'd2,
      FAULT_POWER     = 2'd3
   } fault_type;

   typedef struct packed {
      logic [30:0] min_load_impedance;
      logic [30:0] max_load_impedance;
      logic [23:0] phase_tolerance;
      logic [23:0] power_tolerance;
      logic [30:0] target_power;
      logic [7:0]  failure_limit;
   } cfg_type;

   // Classified request, as it travels through the queue
   typedef struct packed {
      logic action;
      logic triggered;
      logic imp_fail;
      logic ph_fail;
      logic pw_fail;
   } class_type;

endpackage

`default_nettype wire

[rtl/dfwm_front.sv]
// ----------------------------------------------------------------------------
// dfwm_front
// Accepts requests and classifies them: an abs stage, a multiply stage, then the
// window compares. Admission is credit based on the queue behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module dfwm_front #(
   parameter int QUEUE_DEPTH = dfwm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   input  wire logic [dfwm_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire logic [dfwm_pkg::REQ_USER_W-1:0]        req_tuser,
   input  wire dfwm_pkg::cfg_type                      cfg,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_count,
   output logic                                        push,
   output dfwm_pkg::class_type                         push_data
);
   import dfwm_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             accept;
   logic [CNT_W:0]   inflight;

   logic signed [31:0] pr_in, pi_in, zr_in, zi_in;

   // stage 1: magnitudes
   logic               s1_v_ff, s1_v_in;
   logic               s1_action_ff, s1_trig_ff;
   logic [31:0]        s1_azr_ff, s1_azi_ff, s1_api_ff, s1_apr_ff;
   logic [31:0]        s1_azr_in, s1_azi_in, s1_api_in, s1_apr_in;
   logic signed [31:0] s1_pr_ff;

   // stage 2: products
   logic               s2_v_ff;
   logic               s2_action_ff, s2_trig_ff;
   logic [63:0]        s2_sqr_ff, s2_sqi_ff, s2_sqr_in, s2_sqi_in;
   logic [55:0]        s2_ph_rhs_ff, s2_ph_rhs_in;
   logic [31:0]        s2_api_ff;
   logic signed [31:0] s2_pr_ff;

   // thresholds from the registers
   logic [61:0]        lo2_ff, hi2_ff, lo2_in, hi2_in;
   logic [55:0]        upper_ff, upper_in;
   logic signed [56:0] lower_ff, lower_in;
   logic [24:0]        up_factor;
   logic signed [25:0] lo_factor;

   // compare
   logic [64:0]        mag2;
   logic [55:0]        ph_lhs;
   logic signed [57:0] p_ext, upper_ext, lower_ext;

   assign inflight   = (CNT_W+1)'(s1_v_ff) + (CNT_W+1)'(s2_v_ff) + {1'b0, q_count};
   assign req_tready = inflight < (CNT_W+1)'(QUEUE_DEPTH);
   assign accept     = req_tvalid & req_tready;

   assign pr_in = req_tdata[31:0];
   assign pi_in = req_tdata[63:32];
   assign zr_in = req_tdata[95:64];
   assign zi_in = req_tdata[127:96];

   always_comb begin
      s1_v_in   = accept;
      s1_azr_in = zr_in[31] ? 32'(~zr_in + 32'sd1) : 32'(zr_in);
      s1_azi_in = zi_in[31] ? 32'(~zi_in + 32'sd1) : 32'(zi_in);
      s1_api_in = pi_in[31] ? 32'(~pi_in + 32'sd1) : 32'(pi_in);
      s1_apr_in = pr_in[31] ? 32'(~pr_in + 32'sd1) : 32'(pr_in);

      s2_sqr_in    = 64'(s1_azr_ff) * 64'(s1_azr_ff);
      s2_sqi_in    = 64'(s1_azi_ff) * 64'(s1_azi_ff);
      s2_ph_rhs_in = 56'(cfg.phase_tolerance) * 56'(s1_apr_ff);

      up_factor = 25'(ONE_Q16) + 25'(cfg.power_tolerance);
      lo_factor = $signed(26'(ONE_Q16)) - $signed({2'b0, cfg.power_tolerance});
      lo2_in    = 62'(cfg.min_load_impedance) * 62'(cfg.min_load_impedance);
      hi2_in    = 62'(cfg.max_load_impedance) * 62'(cfg.max_load_impedance);
      upper_in  = 56'(up_factor) * 56'(cfg.target_power);
      lower_in  = 57'(lo_factor) * 57'($signed({1'b0, cfg.target_power}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_action_ff <= req_tuser[0];
      s1_trig_ff   <= req_tuser[1];
      s1_azr_ff    <= s1_azr_in;
      s1_azi_ff    <= s1_azi_in;
      s1_api_ff    <= s1_api_in;
      s1_apr_ff    <= s1_apr_in;
      s1_pr_ff     <= pr_in;

      s2_action_ff <= s1_action_ff;
      s2_trig_ff   <= s1_trig_ff;
      s2_sqr_ff    <= s2_sqr_in;
      s2_sqi_ff    <= s2_sqi_in;
      s2_ph_rhs_ff <= s2_ph_rhs_in;
      s2_api_ff    <= s1_api_ff;
      s2_pr_ff     <= s1_pr_ff;

      lo2_ff       <= lo2_in;
      hi2_ff       <= hi2_in;
      upper_ff     <= upper_in;
      lower_ff     <= lower_in;
   end

   // window compares; all exact
   always_comb begin
      mag2      = {1'b0, s2_sqr_ff} + {1'b0, s2_sqi_ff};
      ph_lhs    = {8'b0, s2_api_ff, 16'b0};
      p_ext     = {{10{s2_pr_ff[31]}}, s2_pr_ff, 16'b0};
      upper_ext = $signed({2'b0, upper_ff});
      lower_ext = {lower_ff[56], lower_ff};

      push                = s2_v_ff;
      push_data.action    = s2_action_ff;
      push_data.triggered = s2_trig_ff;
      push_data.imp_fail  = (mag2 < {3'b0, lo2_ff}) || (mag2 > {3'b0, hi2_ff});
      push_data.ph_fail   = ph_lhs > s2_ph_rhs_ff;
      push_data.pw_fail   = (p_ext > upper_ext) || (p_ext < lower_ext);
   end

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      inflight <= (CNT_W+1)'(QUEUE_DEPTH))
      else $error("front: more requests in flight than queue slots");

endmodule

`default_nettype wire

[rtl/dfwm_queue.sv]
// ----------------------------------------------------------------------------
// dfwm_queue
// Short FIFO of classified requests between classifier and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module dfwm_queue #(
   parameter int QUEUE_DEPTH = dfwm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   input  wire dfwm_pkg::class_type               push_data,
   input  wire logic                              pop,
   output logic                                   q_valid,
   output dfwm_pkg::class_type                    q_head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]       q_count
);
   import dfwm_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   class_type          mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_valid = count_ff != '0;
   assign q_count = count_ff;
   assign q_head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < CNT_W'(QUEUE_DEPTH))
      else $error("queue: push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue: pop from empty queue");

endmodule

`default_nettype wire

[rtl/dfwm_back.sv]
// ----------------------------------------------------------------------------
// dfwm_back
// Failure counters, fault priority and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module dfwm_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [dfwm_pkg::COUNT_W-1:0]      failure_limit,
   input  wire logic                              q_valid,
   input  wire dfwm_pkg::class_type               q_head,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dfwm_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import dfwm_pkg::*;

   logic               rsp_valid_ff, rsp_valid_in;
   fault_type          code_ff, code_in;
   logic [COUNT_W-1:0] imp_cnt_ff, ph_cnt_ff, pw_cnt_ff;
   logic [COUNT_W-1:0] imp_cnt_in, ph_cnt_in, pw_cnt_in;
   logic [COUNT_W-1:0] imp_bump, ph_bump, pw_bump;

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c,
                                               input logic fail);
      if (!fail) begin
         return '0;
      end
      return (c == '1) ? c : c + 1'b1;
   endfunction

   // counters double as the response count fields
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, pw_cnt_ff, ph_cnt_ff, imp_cnt_ff, code_ff};

   always_comb begin
      pop          = q_valid && (!rsp_valid_ff || rsp_tready);
      rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_tready);

      imp_bump = bump(imp_cnt_ff, q_head.imp_fail);
      ph_bump  = bump(ph_cnt_ff, q_head.ph_fail);
      pw_bump  = bump(pw_cnt_ff, q_head.pw_fail);

      imp_cnt_in = imp_cnt_ff;
      ph_cnt_in  = ph_cnt_ff;
      pw_cnt_in  = pw_cnt_ff;
      code_in    = code_ff;
      if (pop) begin
         code_in = FAULT_NONE;
         if (q_head.action == ACTION_RESTART) begin
            imp_cnt_in = '0;
            ph_cnt_in  = '0;
            pw_cnt_in  = '0;
         end else if (q_head.triggered) begin
            imp_cnt_in = imp_bump;
            ph_cnt_in  = ph_bump;
            pw_cnt_in  = pw_bump;
            if (imp_bump > failure_limit) begin
               code_in = FAULT_IMPEDANCE;
            end else if (ph_bump > failure_limit) begin
               code_in = FAULT_PHASE;
            end else if (pw_bump > failure_limit) begin
               code_in = FAULT_POWER;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         imp_cnt_ff   <= '0;
         ph_cnt_ff    <= '0;
         pw_cnt_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         imp_cnt_ff   <= imp_cnt_in;
         ph_cnt_ff    <= ph_cnt_in;
         pw_cnt_ff    <= pw_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      pop && (q_head.action == ACTION_RESTART) |=>
         (imp_cnt_ff == '0) && (ph_cnt_ff == '0) && (pw_cnt_ff == '0))
      else $error("back: restart left a counter set");

   a_fault_has_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (code_ff != FAULT_NONE) |->
         ((code_ff == FAULT_IMPEDANCE) && (imp_cnt_ff != '0)) ||
         ((code_ff == FAULT_PHASE) && (ph_cnt_ff != '0)) ||
         ((code_ff == FAULT_POWER) && (pw_cnt_ff != '0)))
      else $error("back: fault raised with a zero counter");

endmodule

`default_nettype wire

[rtl/drive_fault_window_monitor.sv]
// ----------------------------------------------------------------------------
// drive_fault_window_monitor
// Watches impedance window, power phase and power level of a driven load
// and counts successive failures of each check, raising a fault code.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                 Contents
//  req_     in         tvalid/tready             one measurement or restart
//  rsp_     out        tvalid/tready             fault code and three counts
//  csr_     in         psel/penable (pready=1)   six window/limit registers
//
//  Throughput is one request per cycle while req_tready is high. On its way
//  to the response a request passes the abs stage (loaded at the accepting
//  edge), the multiply stage, the compare into the queue, then the counter
//  stage loads the response register.
//  Synchronous reset clears the pipeline, queue and counters and reloads
//  the registers with their defaults; no clearing pass is needed.
//  A stalled response backs up into the queue; req_tready drops once the
//  requests in flight fill every queue slot (QUEUE_DEPTH).
// ----------------------------------------------------------------------------
`default_nettype none

module drive_fault_window_monitor #(
   parameter int QUEUE_DEPTH = dfwm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // power_real[31:0], power_imag[63:32], impedance_real[95:64],
   // impedance_imag[127:96]
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [dfwm_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action[0], triggered[1]
   input  wire logic [dfwm_pkg::REQ_USER_W-1:0]   req_tuser,
   // fault_code[1:0], impedance_fail_count[9:2], phase_fail_count[17:10],
   // power_fail_count[25:18], zero[31:26]
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [dfwm_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [dfwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [dfwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [dfwm_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                   csr_pready
);
   import dfwm_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register file
   cfg_type            cfg_ff, cfg_in;
   logic               csr_write;
   csr_index_type      csr_index;

   // front to queue, queue to back
   logic               push;
   class_type          push_data;
   logic               pop;
   logic               q_valid;
   class_type          q_head;
   logic [CNT_W-1:0]   q_count;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[4:2]);

   // writes mask to register width; unused addresses are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MIN_IMP:    cfg_in.min_load_impedance = csr_pwdata[30:0];
            CSR_MAX_IMP:    cfg_in.max_load_impedance = csr_pwdata[30:0];
            CSR_PHASE_TOL:  cfg_in.phase_tolerance    = csr_pwdata[23:0];
            CSR_POWER_TOL:  cfg_in.power_tolerance    = csr_pwdata[23:0];
            CSR_TARGET_PWR: cfg_in.target_power       = csr_pwdata[30:0];
            CSR_FAIL_LIMIT: cfg_in.failure_limit      = csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_MIN_IMP:    csr_prdata = {1'b0, cfg_ff.min_load_impedance};
         CSR_MAX_IMP:    csr_prdata = {1'b0, cfg_ff.max_load_impedance};
         CSR_PHASE_TOL:  csr_prdata = {8'b0, cfg_ff.phase_tolerance};
         CSR_POWER_TOL:  csr_prdata = {8'b0, cfg_ff.power_tolerance};
         CSR_TARGET_PWR: csr_prdata = {1'b0, cfg_ff.target_power};
         CSR_FAIL_LIMIT: csr_prdata = {24'b0, cfg_ff.failure_limit};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_load_impedance <= MIN_IMP_RESET;
         cfg_ff.max_load_impedance <= MAX_IMP_RESET;
         cfg_ff.phase_tolerance    <= PHASE_TOL_RESET;
         cfg_ff.power_tolerance    <= POWER_TOL_RESET;
         cfg_ff.target_power       <= TARGET_PWR_RESET;
         cfg_ff.failure_limit      <= FAIL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classifier: abs, products, window compares
   dfwm_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_count    (q_count),
      .push       (push),
      .push_data  (push_data)
   );

   dfwm_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_count   (q_count)
   );

   // counters and response register
   dfwm_back u_back (
      .clock         (clock),
      .reset         (reset),
      .failure_limit (cfg_ff.failure_limit),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata)
   );

endmodule

`default_nettype wire

[test/dfwm_fault_checker.sv]
// ----------------------------------------------------------------------------
// dfwm_fault_checker
// Watches the request, response and register ports of the drive fault window
// monitor, keeps its own copy of the window registers and failure counters,
// predicts one status per accepted request and compares each response with
// the oldest prediction in order.
// ----------------------------------------------------------------------------
module dfwm_fault_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [dfwm_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic [dfwm_pkg::REQ_USER_W-1:0]   req_tuser,
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [dfwm_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic                              csr_pready,
   input  wire logic [dfwm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [dfwm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output int                                     mismatch_count,
   output int                                     status_pending
);
   import dfwm_pkg::*;

   // same bit order as rsp_tdata[25:0]
   typedef struct packed {
      logic [COUNT_W-1:0] pw_count;
      logic [COUNT_W-1:0] ph_count;
      logic [COUNT_W-1:0] imp_count;
      fault_type          code;
   } fault_status_type;

   cfg_type            window_cfg;
   logic [COUNT_W-1:0] imp_run;
   logic [COUNT_W-1:0] ph_run;
   logic [COUNT_W-1:0] pw_run;
   fault_status_type   expected_status_q[$];

   initial begin
      mismatch_count = 0;
      status_pending = 0;
   end

   function automatic logic [COUNT_W-1:0] next_run(logic [COUNT_W-1:0] run, logic failed);
      if (!failed)
         return '0;
      return (run == '1) ? run : run + 1'b1;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic fault_status_type predict_fault_status(logic action, logic triggered,
                                                             logic signed [31:0] pr32,
                                                             logic signed [31:0] pi32,
                                                             logic signed [31:0] zr32,
                                                             logic signed [31:0] zi32);
      longint          pr;
      longint          pi;
      longint          zr;
      longint          zi;
      longint          scaled;
      longint          tgt;
      longint          wtol;
      longint          upper;
      longint          lower;
      longint unsigned mag2;
      longint unsigned lo2;
      longint unsigned hi2;
      longint unsigned ptol;
      longint unsigned lhs;
      longint unsigned rhs;
      logic            imp_fail;
      logic            ph_fail;
      logic            pw_fail;
      fault_status_type st;

      st.code = FAULT_NONE;
      if (action == ACTION_RESTART) begin
         imp_run = '0;
         ph_run  = '0;
         pw_run  = '0;
      end else if (triggered) begin
         pr = longint'(pr32);
         pi = longint'(pi32);
         zr = longint'(zr32);
         zi = longint'(zi32);
         // squared magnitude against squared bounds, exact in 64 bits
         mag2 = magnitude(zr) * magnitude(zr) + magnitude(zi) * magnitude(zi);
         lo2  = 64'(window_cfg.min_load_impedance);
         lo2  = lo2 * lo2;
         hi2  = 64'(window_cfg.max_load_impedance);
         hi2  = hi2 * hi2;
         imp_fail = (mag2 < lo2) || (mag2 > hi2);
         // |pi|/|pr| > tol by cross multiplication
         ptol = 64'(window_cfg.phase_tolerance);
         lhs  = magnitude(pi) << 16;
         rhs  = ptol * magnitude(pr);
         ph_fail = lhs > rhs;
         // lower bound goes negative for a tolerance above one
         tgt    = longint'(window_cfg.target_power);
         wtol   = longint'(window_cfg.power_tolerance);
         scaled = pr * ONE_Q16;
         upper  = tgt * (ONE_Q16 + wtol);
         lower  = tgt * (ONE_Q16 - wtol);
         pw_fail = (scaled > upper) || (scaled < lower);

         imp_run = next_run(imp_run, imp_fail);
         ph_run  = next_run(ph_run, ph_fail);
         pw_run  = next_run(pw_run, pw_fail);

         if (imp_run > window_cfg.failure_limit)
            st.code = FAULT_IMPEDANCE;
         else if (ph_run > window_cfg.failure_limit)
            st.code = FAULT_PHASE;
         else if (pw_run > window_cfg.failure_limit)
            st.code = FAULT_POWER;
      end
      st.imp_count = imp_run;
      st.ph_count  = ph_run;
      st.pw_count  = pw_run;
      return st;
   endfunction

   always @(posedge clock) begin
      fault_status_type exp_st;
      fault_status_type act_st;
      if (reset) begin
         window_cfg = '{min_load_impedance: MIN_IMP_RESET,
                        max_load_impedance: MAX_IMP_RESET,
                        phase_tolerance:    PHASE_TOL_RESET,
                        power_tolerance:    POWER_TOL_RESET,
                        target_power:       TARGET_PWR_RESET,
                        failure_limit:      FAIL_LIMIT_RESET};
         imp_run = '0;
         ph_run  = '0;
         pw_run  = '0;
         expected_status_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_index_type'(csr_paddr[4:2]))
               CSR_MIN_IMP:    window_cfg.min_load_impedance = csr_pwdata[30:0];
               CSR_MAX_IMP:    window_cfg.max_load_impedance = csr_pwdata[30:0];
               CSR_PHASE_TOL:  window_cfg.phase_tolerance    = csr_pwdata[23:0];
               CSR_POWER_TOL:  window_cfg.power_tolerance    = csr_pwdata[23:0];
               CSR_TARGET_PWR: window_cfg.target_power       = csr_pwdata[30:0];
               CSR_FAIL_LIMIT: window_cfg.failure_limit      = csr_pwdata[7:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            act_st = rsp_tdata[25:0];
            if (expected_status_q.size() == 0) begin
               $display("%0t unexpected response: expected none, actual %h",
                        $time, rsp_tdata);
               mismatch_count++;
            end else begin
               exp_st = expected_status_q.pop_front();
               if (act_st.code != exp_st.code || act_st.imp_count != exp_st.imp_count ||
                   act_st.ph_count != exp_st.ph_count ||
                   act_st.pw_count != exp_st.pw_count || rsp_tdata[31:26] != '0) begin
                  $display({"%0t status mismatch: expected code=%0d imp=%0d ph=%0d ",
                            "pw=%0d, actual code=%0d imp=%0d ph=%0d pw=%0d pad=%h"},
                           $time, exp_st.code, exp_st.imp_count, exp_st.ph_count,
                           exp_st.pw_count, act_st.code, act_st.imp_count,
                           act_st.ph_count, act_st.pw_count, rsp_tdata[31:26]);
                  mismatch_count++;
               end
            end
         end

         if (req_tvalid && req_tready)
            expected_status_q.push_back(predict_fault_status(req_tuser[0], req_tuser[1],
                                                             req_tdata[31:0],
                                                             req_tdata[63:32],
                                                             req_tdata[95:64],
                                                             req_tdata[127:96]));
      end
      status_pending = expected_status_q.size();
   end

endmodule

[test/tb_drive_fault_window_monitor.sv]
// ----------------------------------------------------------------------------
// tb_drive_fault_window_monitor
// Regression of the drive fault window monitor: a directed pass over window
// boundaries, special inputs and fault priority, then random phases with
// several register settings and idle mixes, checked by dfwm_fault_checker.
// ----------------------------------------------------------------------------
module tb_drive_fault_window_monitor;
   import dfwm_pkg::*;

   localparam longint INT32_MAX       = 64'sd2147483647;
   localparam longint INT32_MIN       = -64'sd2147483648;
   localparam longint NOM_POWER       = 6553600;   // 100 W
   localparam longint NOM_OHMS        = 3276800;   // 50 ohm
   localparam int     WATCHDOG_LIMIT  = 3000;
   localparam int     HOLD_OFF_CYCLES = 300;
   localparam int     DRAIN_CYCLES    = 10;        // response latency plus margin

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   wire                   req_tready;
   wire                   rsp_tvalid;
   wire [RSP_DATA_W-1:0]  rsp_tdata;
   wire [CSR_DATA_W-1:0]  csr_prdata;
   wire                   csr_pready;
   int                    mismatch_count;
   int                    status_pending;

   // traffic shaping, changed per phase
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;
   bit hold_off_pending = 0;
   int quiet_cycles     = 0;

   // stimulus copy of the registers and the per-check failure tendency
   cfg_type drive_cfg;
   bit      imp_bad;
   bit      ph_bad;
   bit      pw_bad;
   int      flip_pct;
   int      match_pct;
   int      restart_pct;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   drive_fault_window_monitor DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dfwm_fault_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatch_count (mismatch_count),
      .status_pending (status_pending)
   );

   // Watchdog: any cycle without a handshake on some port counts toward the
   // limit. The long receiver hold-off stays well below it.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("drive_fault_window_monitor regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: random stalls at the phase's rate. A hold-off request
   // parks tready low for a fixed stretch so the queue fills and req_tready
   // drops while the sender keeps offering.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Register write: setup, then access until pready. Entered and left on a
   // falling edge with nothing yet driven in that step.
   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_window(logic [30:0] lo_ohm, logic [30:0] hi_ohm,
                                 logic [23:0] ph_tol, logic [23:0] pw_tol,
                                 logic [30:0] tgt, logic [7:0] limit);
      write_reg(CSR_MIN_IMP, 32'(lo_ohm));
      write_reg(CSR_MAX_IMP, 32'(hi_ohm));
      write_reg(CSR_PHASE_TOL, 32'(ph_tol));
      write_reg(CSR_POWER_TOL, 32'(pw_tol));
      write_reg(CSR_TARGET_PWR, 32'(tgt));
      write_reg(CSR_FAIL_LIMIT, 32'(limit));
      drive_cfg = '{min_load_impedance: lo_ohm, max_load_impedance: hi_ohm,
                    phase_tolerance: ph_tol, power_tolerance: pw_tol,
                    target_power: tgt, failure_limit: limit};
   endtask

   // One request. Idle cycles come first, each with a per-cycle chance, then
   // tvalid stays up until the accepting edge. Returns on the next falling
   // edge with nothing driven there yet.
   task automatic send_request(logic action, logic triggered,
                               longint pr, longint pi, longint zr, longint zi);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {triggered, action};
      req_tdata  <= {zi[31:0], zr[31:0], pi[31:0], pr[31:0]};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain();
      while (status_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Random 32-bit word, all bits free.
   function automatic longint rand_word();
      return longint'($urandom);
   endfunction

   // Uniform pick with extra weight on both ends of the range.
   function automatic longint pick_between(longint lo, longint hi);
      longint unsigned span;
      if (hi <= lo)
         return lo;
      case ($urandom_range(0, 9))
         0:       return lo;
         1:       return hi;
         default: begin
            span = hi - lo + 1;
            return lo + longint'({$urandom, $urandom} % span);
         end
      endcase
   endfunction

   // Random measurement aimed at the current windows: each check mostly
   // follows its tendency, and tendencies flip now and then so failure runs
   // build up past the limit and then clear.
   task automatic random_request();
      longint pr, pi, zr, zi, m, lo, hi, band, lim;
      longint lo_ohm, hi_ohm, tgt, pw_tol, ph_tol;
      bit     imp_fail, ph_fail, pw_fail, corner;
      int     roll;

      roll = $urandom_range(0, 99);
      if (roll < restart_pct) begin
         send_request(ACTION_RESTART, 1'($urandom_range(0, 1)), rand_word(), rand_word(),
                      rand_word(), rand_word());
      end else if (roll < restart_pct + 4) begin
         // ignored by the block, counters hold
         send_request(ACTION_SAMPLE, 1'b0, rand_word(), rand_word(), rand_word(),
                      rand_word());
      end else if (roll < restart_pct + 9) begin
         // raw noise, all bits free
         send_request(ACTION_SAMPLE, 1'b1, rand_word(), rand_word(), rand_word(),
                      rand_word());
      end else begin
         if ($urandom_range(0, 99) < flip_pct) imp_bad = !imp_bad;
         if ($urandom_range(0, 99) < flip_pct) ph_bad  = !ph_bad;
         if ($urandom_range(0, 99) < flip_pct) pw_bad  = !pw_bad;
         imp_fail = ($urandom_range(0, 99) < match_pct) ? imp_bad : !imp_bad;
         ph_fail  = ($urandom_range(0, 99) < match_pct) ? ph_bad  : !ph_bad;
         pw_fail  = ($urandom_range(0, 99) < match_pct) ? pw_bad  : !pw_bad;
         lo_ohm = drive_cfg.min_load_impedance;
         hi_ohm = drive_cfg.max_load_impedance;
         tgt    = drive_cfg.target_power;
         pw_tol = drive_cfg.power_tolerance;
         ph_tol = drive_cfg.phase_tolerance;

         // impedance magnitude inside, below or above the window
         corner = 0;
         if (!imp_fail)
            m = (lo_ohm <= hi_ohm) ? pick_between(lo_ohm, hi_ohm)
                                   : pick_between(0, INT32_MAX);
         else if ($urandom_range(0, 1) && lo_ohm > 0)
            m = pick_between(0, lo_ohm - 1);
         else if (hi_ohm < INT32_MAX)
            m = pick_between(hi_ohm + 1, INT32_MAX);
         else if (lo_ohm > 0)
            m = pick_between(0, lo_ohm - 1);
         else begin
            // window spans every axis value: only the diagonal gets above it
            m = INT32_MAX;
            corner = 1;
         end
         case (corner ? 3 : $urandom_range(0, 2))
            0:       begin zr = m; zi = 0; end
            1:       begin zr = 0; zi = m; end
            2:       begin zr = (m * 181) >>> 8; zi = zr; end
            default: begin zr = m; zi = m; end
         endcase
         if ($urandom_range(0, 1)) zr = -zr;
         if ($urandom_range(0, 1)) zi = -zi;

         // real power inside or outside target * (1 +/- tol)
         band = (tgt * pw_tol) >>> 16;
         lo   = tgt - band;
         hi   = tgt + band;
         if (lo < INT32_MIN) lo = INT32_MIN;
         if (hi > INT32_MAX) hi = INT32_MAX;
         if ($urandom_range(0, 24) == 0)
            pr = 0;
         else if (!pw_fail)
            pr = pick_between(lo, hi);
         else if ($urandom_range(0, 1) && hi < INT32_MAX)
            pr = pick_between(hi + 1, INT32_MAX);
         else if (lo > INT32_MIN)
            pr = pick_between(INT32_MIN, lo - 1);
         else if (hi < INT32_MAX)
            pr = pick_between(hi + 1, INT32_MAX);
         else
            pr = pick_between(lo, hi);

         // imaginary power against tol * |pr|
         lim = (ph_tol * ((pr < 0) ? -pr : pr)) >>> 16;
         if (lim > INT32_MAX) lim = INT32_MAX;
         if (ph_fail && lim < INT32_MAX)
            pi = pick_between(lim + 1, INT32_MAX);
         else
            pi = pick_between(0, lim);
         if ($urandom_range(0, 1)) pi = -pi;

         send_request(ACTION_SAMPLE, 1'b1, pr, pi, zr, zi);
      end
   endtask

   // One random phase; hold_at picks the request before which the receiver
   // goes into its long hold-off (negative: none).
   task automatic run_phase(int count, int idle, int stall, int flip, int match,
                            int restarts, int hold_at);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      flip_pct       = flip;
      match_pct      = match;
      restart_pct    = restarts;
      for (int i = 0; i < count; i++) begin
         if (i == hold_at)
            hold_off_pending = 1;
         random_request();
      end
      req_tvalid <= 1'b0;
      drain();
   endtask

   initial begin
      imp_bad = 1'($urandom_range(0, 1));
      ph_bad  = 1'($urandom_range(0, 1));
      pw_bad  = 1'($urandom_range(0, 1));

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // --- directed, reset window: 10..1000 ohm, tol 0.1, 100 W, limit 10
      program_window(MIN_IMP_RESET, MAX_IMP_RESET, PHASE_TOL_RESET, POWER_TOL_RESET,
                     TARGET_PWR_RESET, FAIL_LIMIT_RESET);
      send_request(ACTION_RESTART, 1'b0, 0, 0, 0, 0);
      send_request(ACTION_SAMPLE, 1'b1, NOM_POWER, 0, NOM_OHMS, 0);
      // untriggered with extreme contents must leave counters alone
      send_request(ACTION_SAMPLE, 1'b0, INT32_MIN, INT32_MAX, -1, 0);
      // zero real power: 0/0 passes phase, nonzero imaginary fails it
      send_request(ACTION_SAMPLE, 1'b1, 0, 0, NOM_OHMS, 0);
      send_request(ACTION_SAMPLE, 1'b1, 0, 1, NOM_OHMS, 0);
      // extreme impedance and power values
      send_request(ACTION_SAMPLE, 1'b1, INT32_MAX, INT32_MIN, INT32_MIN, INT32_MIN);
      send_request(ACTION_SAMPLE, 1'b1, -1, -1, INT32_MAX, INT32_MAX);
      send_request(ACTION_SAMPLE, 1'b1, NOM_POWER, 0, 0, 0);
      // restart wins over a trigger
      send_request(ACTION_RESTART, 1'b1, -1, -1, -1, -1);
      // exact boundaries of each window, one step in and one step out
      send_request(ACTION_SAMPLE, 1'b1, 7209000, 0, 655360, 0);
      send_request(ACTION_SAMPLE, 1'b1, 7209001, 0, 655359, 0);
      send_request(ACTION_SAMPLE, 1'b1, 5898200, 0, 0, 65536000);
      send_request(ACTION_SAMPLE, 1'b1, 5898199, 0, 0, -65536001);
      send_request(ACTION_SAMPLE, 1'b1, NOM_POWER, 655400, NOM_OHMS, 0);
      send_request(ACTION_SAMPLE, 1'b1, -NOM_POWER, -655401, NOM_OHMS, 0);
      req_tvalid <= 1'b0;
      drain();

      // --- directed fault priority with limit 0: first failure raises it
      program_window(MIN_IMP_RESET, MAX_IMP_RESET, PHASE_TOL_RESET, POWER_TOL_RESET,
                     TARGET_PWR_RESET, 8'd0);
      send_request(ACTION_SAMPLE, 1'b1, NOM_POWER, 0, 0, 0);
      send_request(ACTION_SAMPLE, 1'b1, NOM_POWER, NOM_POWER, NOM_OHMS, 0);
      send_request(ACTION_SAMPLE, 1'b1, 2 * NOM_POWER, 0, NOM_OHMS, 0);
      send_request(ACTION_SAMPLE, 1'b1, 0, 1, 0, 0);
      send_request(ACTION_SAMPLE, 1'b0, 0, 1, 0, 0);
      send_request(ACTION_SAMPLE, 1'b1, NOM_POWER, 0, NOM_OHMS, 0);
      req_tvalid <= 1'b0;
      drain();

      // --- random phases
      // reset settings, back to back
      program_window(MIN_IMP_RESET, MAX_IMP_RESET, PHASE_TOL_RESET, POWER_TOL_RESET,
                     TARGET_PWR_RESET, FAIL_LIMIT_RESET);
      run_phase(180, 0, 0, 8, 85, 2, -1);

      // narrower impedance, wide phase, sender idling
      program_window(31'd1310720, 31'd13107200, 24'h008000, 24'h002000, 31'd3276800,
                     8'($urandom_range(1, 15)));
      run_phase(180, 51, 0, 8, 85, 2, -1);

      // top phase tolerance, power tolerance above one, receiver stalling
      program_window(31'd65536, 31'd6553600, 24'hFFFFFF, 24'h030000, 31'd6553600, 8'd3);
      run_phase(180, 0, 51, 10, 80, 2, -1);

      // inverted window: every magnitude fails; both sides idling
      program_window(31'h7FFFFFFF, 31'd0, 24'd6554, 24'd6554, 31'd6553600, 8'd5);
      run_phase(180, 30, 30, 10, 80, 2, -1);

      // widest window, zero phase tolerance, top power settings, limit 0,
      // with a long receiver hold-off while requests keep coming
      program_window(31'd0, 31'h7FFFFFFF, 24'd0, 24'hFFFFFF, 31'h7FFFFFFF, 8'd0);
      run_phase(180, 0, 0, 10, 80, 2, 40);

      // zero target and tolerance, limit 255: long failure runs saturate the
      // counters and still never raise a fault
      program_window(MIN_IMP_RESET, MAX_IMP_RESET, PHASE_TOL_RESET, 24'd0, 31'd0, 8'd255);
      imp_bad = 1;
      ph_bad  = 1;
      pw_bad  = 1;
      run_phase(300, 0, 0, 0, 100, 0, -1);

      if (mismatch_count == 0 && status_pending == 0)
         $display("drive_fault_window_monitor regression: pass");
      else
         $display("drive_fault_window_monitor regression: fail");
      $finish;
   end

endmodule
